/* design/rpn_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// No dependencies. Used by rpn_cell, rpn_div and postfix_expression_evaluator.
`default_nettype none

package rpn_pkg;

   localparam int DATA_W          = 32;
   localparam int STACK_DEPTH_DEF = 16;

   // token kinds
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER  = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_DEPTH = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] digit;
      logic       last;
   } req_fields_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rsp_fields_type;

   // per-cell shift control: take the entry above (push) or below (pop)
   typedef struct packed {
      logic take_above;
      logic take_below;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* design/rpn_cell.sv */
// One stack cell: holds one 32-bit operand, shifts toward either neighbor.
// Depends on rpn_pkg.
`default_nettype none

module rpn_cell (
   input  wire logic                       clock,
   input  wire rpn_pkg::cell_ctl_type      ctl,
   input  wire logic [rpn_pkg::DATA_W-1:0] above,
   input  wire logic [rpn_pkg::DATA_W-1:0] below,
   output logic      [rpn_pkg::DATA_W-1:0] entry
);

   logic [rpn_pkg::DATA_W-1:0] entry_ff;
   logic [rpn_pkg::DATA_W-1:0] entry_in;

   always_comb begin
      priority if (ctl.take_above) begin
         entry_in = above;
      end else if (ctl.take_below) begin
         entry_in = below;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* design/rpn_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on rpn_pkg. Divisor must be nonzero at start.
`default_nettype none

module rpn_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rpn_pkg::DATA_W-1:0] num,
   input  wire logic [rpn_pkg::DATA_W-1:0] den,
   output logic                            busy,
   output logic                            done,
   output logic      [rpn_pkg::DATA_W-1:0] quot
);

   localparam int W  = rpn_pkg::DATA_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  qt_ff, qt_in;
   logic [W-1:0]  ud_ff, ud_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qt_in   = qt_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      shifted = {rem_ff, qt_ff[W-1]};
      diff    = shifted - {1'b0, ud_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         qt_in   = num[W-1] ? (~num + 1'b1) : num;
         ud_in   = den[W-1] ? (~den + 1'b1) : den;
         neg_in  = num[W-1] ^ den[W-1];
      end else if (busy_ff) begin
         rem_in = diff[W] ? shifted[W-1:0] : diff[W-1:0];
         qt_in  = {qt_ff[W-2:0], ~diff[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // sign fix-up as a separate registered step after the last quotient bit
         quot_in = neg_ff ? (~qt_ff + 1'b1) : qt_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      qt_ff   <= qt_in;
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff | fin_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

/* design/postfix_expression_evaluator.sv */
// Postfix (reverse Polish) expression evaluator, top level.
// Depends on rpn_pkg, rpn_cell (operand stack chain) and rpn_div (divider).
//
//   channel | direction | payload                     | handshake
//   --------+-----------+-----------------------------+----------------------------
//   req     | in        | req_fields_type op/digit/last | req_valid / req_stall (out)
//   rsp     | out       | rsp_fields_type value/status  | rsp_valid / rsp_stall (in)
//
// Sequence: one token at a time. Push, unknown op, a token after an error or one that
//   raises an error: accept, execute, finish. Add/sub/mul add a commit step that pops
//   the chain. Divide waits on the divider, which retires one quotient bit per cycle
//   and then does its sign fix-up, before the commit and finish steps.
// Reset: synchronous, active high; clears depth, error, state and output valid.
//   Stack cells are not reset; only live entries are ever read.
// Stalls: the result sits in an output register; new tokens are taken while it
//   waits. A last token stalls in its finish cycle only if the previous result
//   is still pending.
`default_nettype none

module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire rpn_pkg::req_fields_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rpn_pkg::rsp_fields_type      rsp_data
);

   localparam int W  = rpn_pkg::DATA_W;
   localparam int DW = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic [2:0]              err_ff, err_in;
   rpn_pkg::req_fields_type tok_ff, tok_in;
   logic [W-1:0]            res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rpn_pkg::rsp_fields_type rsp_ff, rsp_in;

   // stack chain: cell 0 is the top of stack
   rpn_pkg::cell_ctl_type   cell_ctl [STACK_DEPTH];
   logic [W-1:0]            cell_q   [STACK_DEPTH];
   logic [W-1:0]            top_data;
   logic                    do_push;
   logic                    do_pop;

   logic [W-1:0]            rhs;
   logic [W-1:0]            lhs;
   logic                    div_start;
   logic                    div_busy;
   logic                    div_done;
   logic [W-1:0]            div_quot;
   logic                    rsp_hold;
   logic [2:0]              fin_status;

   assign rhs = cell_q[0];
   assign lhs = cell_q[1];

   // push loads cell 0 with the digit and shifts everything down;
   // commit loads cell 0 with the result and shifts the rest up
   assign top_data = (state_ff == S_EXEC) ? W'(tok_ff.digit) : res_ff;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [W-1:0] above;
      logic [W-1:0] below;
      if (i == 0) begin : g_top
         assign above = top_data;
         assign cell_ctl[i].take_above = do_push | do_pop;
         assign cell_ctl[i].take_below = 1'b0;
      end else begin : g_rest
         assign above = cell_q[i-1];
         assign cell_ctl[i].take_above = do_push;
         assign cell_ctl[i].take_below = do_pop;
      end
      if (i == STACK_DEPTH - 1) begin : g_end
         assign below = cell_q[i];
      end else begin : g_mid
         assign below = cell_q[i+1];
      end
      rpn_cell u_cell (
         .clock (clock),
         .ctl   (cell_ctl[i]),
         .above (above),
         .below (below),
         .entry (cell_q[i])
      );
   end

   rpn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (lhs),
      .den   (rhs),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_hold = rsp_valid_ff & rsp_stall;

   always_comb begin
      fin_status = err_ff;
      if (err_ff == rpn_pkg::ST_OK && depth_ff != DW'(1)) begin
         fin_status = rpn_pkg::ST_DEPTH;
      end
   end

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      err_in       = err_ff;
      tok_in       = tok_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tok_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (err_ff == rpn_pkg::ST_OK) begin
               unique case (tok_ff.op)
                  rpn_pkg::OP_PUSH: begin
                     if (depth_ff == DW'(STACK_DEPTH)) begin
                        err_in = rpn_pkg::ST_OVER;
                     end else begin
                        do_push  = 1'b1;
                        depth_in = depth_ff + 1'b1;
                     end
                  end
                  rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                  rpn_pkg::OP_DIV: begin
                     if (depth_ff < DW'(2)) begin
                        err_in = rpn_pkg::ST_UNDER;
                     end else if (tok_ff.op == rpn_pkg::OP_ADD) begin
                        res_in   = lhs + rhs;
                        state_in = S_COMMIT;
                     end else if (tok_ff.op == rpn_pkg::OP_SUB) begin
                        res_in   = lhs - rhs;
                        state_in = S_COMMIT;
                     end else if (tok_ff.op == rpn_pkg::OP_MUL) begin
                        res_in   = lhs * rhs;   // low word only, wraps
                        state_in = S_COMMIT;
                     end else if (rhs == '0) begin
                        err_in = rpn_pkg::ST_DIVZ;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     // unknown token kind: stack untouched
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            do_pop   = 1'b1;
            depth_in = depth_ff - 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!tok_ff.last) begin
               state_in = S_IDLE;
            end else if (!rsp_hold) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = fin_status;
               rsp_in.value  = (fin_status == rpn_pkg::ST_OK) ? cell_q[0] : '0;
               depth_in      = '0;
               err_in        = rpn_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         err_ff       <= rpn_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff <= tok_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack depth never runs past the chain length
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond chain length");

   // divider only runs while the sequencer waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == S_DIV)
      else $error("divider busy outside divide wait");

   // a delivered result clears the expression state
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && tok_ff.last && !rsp_hold)
      |=> (depth_ff == '0 && err_ff == rpn_pkg::ST_OK && rsp_valid_ff))
      else $error("expression state not cleared after last token");

   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != rpn_pkg::ST_OK) |-> rsp_ff.value == '0)
      else $error("error result with nonzero value");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for postfix_expression_evaluator: directed and random token streams.
// Depends on rpn_pkg for the token and result payload types and the op and status codes.
// A scoreboard class mirrors the operand stack and checks every result transaction in order.

module tb_top;
   import rpn_pkg::*;

   // op codes the block must ignore (still honoring last)
   localparam logic [2:0] OP_BAD_LO = 3'd5;
   localparam logic [2:0] OP_BAD_HI = 3'd7;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   // a divide is the slowest token; stalls at 74% add long tails on top
   localparam int QUIET_LIMIT  = 4000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_TOKENS = 400;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors stack, depth and sticky error of the evaluator.
   // eval_token() runs on every accepted token transaction and queues the
   // result a last token produces; check_result() pops the oldest one.
   // ------------------------------------------------------------------
   class rpn_scoreboard;
      logic [31:0]    operand_mirror [STACK_DEPTH_DEF];
      int unsigned    live_depth;
      logic [2:0]     first_error;
      rsp_fields_type results_due [$];
      int unsigned    mismatches;
      int unsigned    tokens_seen;
      int unsigned    results_seen;
      int unsigned    status_hits [8];

      function new();
         live_depth  = 0;
         first_error = ST_OK;
         mismatches  = 0;
         tokens_seen = 0;
         results_seen = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function void eval_token(req_fields_type t);
         logic [31:0]    rhs, lhs, res, un, ud, q;
         bit             commit;
         rsp_fields_type r;
         tokens_seen++;
         // once an error is latched, the rest of the expression is dead
         if (first_error == ST_OK) begin
            case (t.op)
               OP_PUSH: begin
                  if (live_depth >= STACK_DEPTH_DEF) begin
                     first_error = ST_OVER;
                  end else begin
                     operand_mirror[live_depth] = {28'd0, t.digit};
                     live_depth++;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (live_depth < 2) begin
                     first_error = ST_UNDER;
                  end else begin
                     rhs    = operand_mirror[live_depth - 1];
                     lhs    = operand_mirror[live_depth - 2];
                     commit = 1'b1;
                     res    = '0;
                     case (t.op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;     // low 32 bits, wraps
                        default: begin
                           if (rhs == 32'd0) begin
                              first_error = ST_DIVZ;
                              commit      = 1'b0;
                           end else begin
                              // magnitude divide, then sign; min / -1 wraps to min
                              un  = lhs[31] ? -lhs : lhs;
                              ud  = rhs[31] ? -rhs : rhs;
                              q   = un / ud;
                              res = (lhs[31] ^ rhs[31]) ? -q : q;
                           end
                        end
                     endcase
                     if (commit) begin
                        live_depth--;
                        operand_mirror[live_depth - 1] = res;
                     end
                  end
               end
               default: ;   // unknown op: no stack effect
            endcase
         end
         if (t.last) begin
            r.status = first_error;
            if (first_error == ST_OK && live_depth != 1) r.status = ST_DEPTH;
            r.value = (r.status == ST_OK) ? operand_mirror[0] : 32'sd0;
            results_due.push_back(r);
            live_depth  = 0;
            first_error = ST_OK;
         end
      endfunction

      function void check_result(rsp_fields_type got);
         rsp_fields_type want;
         if (results_due.size() == 0) begin
            $error("result transaction with none expected: value %0d status %0d",
                   got.value, got.status);
            mismatches++;
            return;
         end
         want = results_due.pop_front();
         results_seen++;
         status_hits[want.status]++;
         if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   req_fields_type req_data  = '0;
   logic           rsp_stall = 1'b0;
   logic           req_stall;
   logic           rsp_valid;
   rsp_fields_type rsp_data;

   int             send_idle_pct = 0;    // chance per cycle the sender holds off
   int             rsp_stall_pct = 0;    // chance per cycle the receiver stalls
   int unsigned    tokens_sent   = 0;
   int unsigned    quiet_cycles  = 0;
   rpn_scoreboard  book;

   always #HALF_PERIOD clock = ~clock;

   postfix_expression_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------
   // Monitor and receiver. Everything read here is the value present at
   // the edge; our own drives are nonblocking so they land after it.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) book.eval_token(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Watchdog: too long with no transaction on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks
   // ------------------------------------------------------------------

   // One token transaction. Valid stays high when the next token follows
   // at once; it only drops when a hold-off cycle is drawn or the sender waits for results.
   task automatic send_token(input req_fields_type t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens_sent++;
   endtask

   task automatic put(input logic [2:0] op, input logic [3:0] digit, input logic last);
      req_fields_type t;
      t.op    = op;
      t.digit = digit;
      t.last  = last;
      send_token(t);
   endtask

   // Sender goes quiet until every queued result has been checked.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [2:0] pick_operator();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return OP_ADD;
      if (r < 50) return OP_SUB;
      if (r < 85) return OP_MUL;     // products grow fast and exercise the wrap
      return OP_DIV;
   endfunction

   // Well-formed expression with random digits and operators; ends at depth one.
   // Mostly shallow, sometimes deep enough to nearly fill the stack.
   task automatic send_wellformed();
      int             pushes_left;
      int             depth;
      req_fields_type t;
      pushes_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                : $urandom_range(1, 6);
      depth = 0;
      while (pushes_left > 0 || depth > 1) begin
         if (pushes_left > 0 &&
             (depth < 2 || (depth < STACK_DEPTH_DEF && $urandom_range(0, 2) != 0))) begin
            t.op    = OP_PUSH;
            t.digit = 4'($urandom_range(0, 15));
            pushes_left--;
            depth++;
         end else begin
            t.op    = pick_operator();
            t.digit = 4'($urandom_range(0, 15));   // don't-care, randomized anyway
            depth--;
         end
         t.last = (pushes_left == 0 && depth == 1);
         send_token(t);
      end
   endtask

   // Builds 2^31 (the most negative value) from 8^10 * 2, then either
   // divides or multiplies it by -1, or subtracts one to wrap to the max.
   task automatic send_int_min_case();
      put(OP_PUSH, 4'd8, 1'b0);
      repeat (9) begin
         put(OP_PUSH, 4'd8, 1'b0);
         put(OP_MUL, 4'($urandom_range(0, 15)), 1'b0);
      end
      put(OP_PUSH, 4'd2, 1'b0);
      put(OP_MUL, 4'($urandom_range(0, 15)), 1'b0);
      case ($urandom_range(0, 2))
         0: begin
            put(OP_PUSH, 4'd0, 1'b0);
            put(OP_PUSH, 4'd1, 1'b0);
            put(OP_SUB, 4'd0, 1'b0);
            put(OP_DIV, 4'd0, 1'b1);
         end
         1: begin
            put(OP_PUSH, 4'd0, 1'b0);
            put(OP_PUSH, 4'd1, 1'b0);
            put(OP_SUB, 4'd0, 1'b0);
            put(OP_MUL, 4'd0, 1'b1);
         end
         default: begin
            put(OP_PUSH, 4'd1, 1'b0);
            put(OP_SUB, 4'd0, 1'b1);
         end
      endcase
   endtask

   // Fills the stack: exactly full then reduced, or pushed past full.
   task automatic send_full_stack();
      int n;
      n = $urandom_range(16, 18);
      for (int i = 0; i < n; i++)
         put(OP_PUSH, 4'($urandom_range(0, 15)), (n > 16 && i == n - 1));
      if (n == 16)
         for (int i = 0; i < 15; i++)
            put(pick_operator(), 4'($urandom_range(0, 15)), (i == 14));
   endtask

   // Unstructured tokens: unknown ops, stray lasts, underflows.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         put(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
             ($urandom_range(0, 3) == 0));
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int unsigned start;
      int          pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = tokens_sent;
      send_int_min_case();
      send_full_stack();
      while (tokens_sent - start < PHASE_TOKENS) begin
         pick = $urandom_range(0, 99);
         if (pick < 72)
            send_wellformed();
         else if (pick < 76)
            send_int_min_case();
         else if (pick < 80)
            send_full_stack();
         else
            send_noise();
      end
      wait_for_results();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: one expression per special case, no idling
      put(OP_PUSH, 4'd9, 1'b1);                                   // single digit, largest decimal digit
      put(OP_PUSH, 4'd0, 1'b1);                                   // single digit, zero
      put(OP_PUSH, 4'd7, 1'b0); put(OP_PUSH, 4'd5, 1'b0);
      put(OP_SUB, 4'd0, 1'b1);                                    // 7 - 5 (operand order)
      put(OP_PUSH, 4'd0, 1'b0); put(OP_PUSH, 4'd7, 1'b0);
      put(OP_SUB, 4'd0, 1'b0); put(OP_PUSH, 4'd2, 1'b0);
      put(OP_DIV, 4'd0, 1'b1);                                    // -7 / 2 truncates to -3
      put(OP_PUSH, 4'd8, 1'b0); put(OP_PUSH, 4'd9, 1'b0);
      put(OP_ADD, 4'd0, 1'b1);                                    // add
      put(OP_PUSH, 4'd15, 1'b0); put(OP_PUSH, 4'd6, 1'b0);
      put(OP_MUL, 4'd0, 1'b1);                                    // digit above nine, mul
      put(OP_PUSH, 4'd9, 1'b0); put(OP_PUSH, 4'd0, 1'b0);
      put(OP_DIV, 4'd0, 1'b1);                                    // divide by zero
      put(OP_ADD, 4'd15, 1'b1);                                   // underflow on empty stack
      put(OP_SUB, 4'd0, 1'b0); put(OP_PUSH, 4'd5, 1'b1);          // sticky: first error wins
      put(OP_PUSH, 4'd3, 1'b0); put(OP_PUSH, 4'd4, 1'b1);         // end depth two
      put(OP_BAD_HI, 4'd10, 1'b1);                                // unknown op, empty at end
      put(OP_PUSH, 4'd4, 1'b0); put(OP_BAD_LO, 4'd0, 1'b1);       // unknown op leaves depth one
      wait_for_results();

      // random: no idling, sender idle, receiver stalling, both
      run_phase(0, 0);
      run_phase(74, 0);
      run_phase(0, 74);
      run_phase(32, 32);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d tokens through four idling phases; %0d results checked.",
               book.tokens_seen, book.results_seen);
      $display("Statuses ok/underflow/overflow/div-by-zero/bad-depth: %0d/%0d/%0d/%0d/%0d",
               book.status_hits[ST_OK], book.status_hits[ST_UNDER], book.status_hits[ST_OVER],
               book.status_hits[ST_DIVZ], book.status_hits[ST_DEPTH]);
      if (book.mismatches == 0 && book.results_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
design/rpn_pkg.sv
design/rpn_cell.sv
design/rpn_div.sv
design/postfix_expression_evaluator.sv
dv/tb_top.sv
